// ===== sv/csp_pkg.sv =====
package csp_pkg;

    // Lane and field geometry
    localparam int HW_CLASSES = 8;
    localparam int CNT_W      = 8;
    localparam int SCORE_W    = 16;
    localparam int IDX_W      = 3;
    localparam int MAG_W      = 17;
    localparam int SQ_W       = 31;
    localparam int CONF_W     = 7;
    localparam int LEVEL_W    = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CCOUNT_W   = 4;

    // Percent scale for confidence and anomaly level
    localparam logic [6:0] PCT_SCALE = 7'd100;

    // Register reset values
    localparam logic [CCOUNT_W-1:0]   RST_CLASS_COUNT  = 4'd8;
    localparam logic [CFG_DATA_W-1:0] RST_COUNT_LIMITS = 64'h0101_0101_01EE_8202;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLASS_COUNT  = 3'd0,
        CFG_COUNT_LIMITS = 3'd1,
        CFG_PROB_LOW     = 3'd2,
        CFG_PROB_HIGH    = 3'd3,
        CFG_GAME_MODE    = 3'd4
    } t_cfg_idx;

    // Game modes that route game events
    localparam logic [MODE_W-1:0] MODE_SWAPPED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MIRROR  = 2'd3;

    // Event kinds
    localparam logic EVT_GESTURE = 1'b0;
    localparam logic EVT_GAME    = 1'b1;

    // Winner found by the merge stage
    typedef struct packed {
        logic               fire;
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
    } t_pick;

    // Event handed to the output pipeline
    typedef struct packed {
        logic               game;
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        logic [MAG_W-1:0]   mag;
        logic [MODE_W-1:0]  mode;
    } t_evt;

    // Gesture code: classes 3 and 7 trade places
    function automatic logic [IDX_W-1:0] map_code(input logic [IDX_W-1:0] c);
        logic [IDX_W-1:0] r;
        case (c)
            3'd3:    r = 3'd7;
            3'd7:    r = 3'd3;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/csp_if.sv =====
interface csp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] score_0;
    logic [15:0] score_1;
    logic [15:0] score_2;
    logic [15:0] score_3;
    logic [15:0] score_4;
    logic [15:0] score_5;
    logic [15:0] score_6;
    logic [15:0] score_7;
    logic signed [15:0] anomaly_score;
    logic        audio_busy;

    modport source (
        output valid, score_0, score_1, score_2, score_3, score_4, score_5,
               score_6, score_7, anomaly_score, audio_busy,
        input  ready
    );
    modport sink (
        input  valid, score_0, score_1, score_2, score_3, score_4, score_5,
               score_6, score_7, anomaly_score, audio_busy,
        output ready
    );
endinterface

interface csp_out_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [2:0]  gesture_code;
    logic [6:0]  confidence_pct;
    logic [15:0] anomaly_level;
    logic [1:0]  mode_echo;

    modport source (
        output valid, event_kind, gesture_code, confidence_pct, anomaly_level, mode_echo,
        input  ready
    );
    modport sink (
        input  valid, event_kind, gesture_code, confidence_pct, anomaly_level, mode_echo,
        output ready
    );
endinterface

interface csp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== sv/csp_lane.sv =====
module csp_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_in_use,
    input  logic                         i_clear,
    input  logic [csp_pkg::SCORE_W-1:0]  i_score,
    input  logic [csp_pkg::SCORE_W-1:0]  i_prob_limit,
    input  logic [csp_pkg::CNT_W-1:0]    i_count_limit,
    output logic                         o_hit
);

    logic [csp_pkg::CNT_W-1:0] r_cnt;
    logic [csp_pkg::CNT_W-1:0] n_cnt;

    // Extend the run on a hit, drop it on a miss; idle lanes hold
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_use) begin
            if (i_score >= i_prob_limit) begin
                n_cnt = r_cnt + csp_pkg::CNT_W'(1);
            end else begin
                n_cnt = '0;
            end
        end
    end

    assign o_hit = i_in_use && (n_cnt == i_count_limit);

    // Commit on transfer; any firing clears every lane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            r_cnt <= i_clear ? '0 : n_cnt;
        end
    end

endmodule

// ===== sv/csp_merge.sv =====
module csp_merge (
    input  logic                        i_hit   [csp_pkg::HW_CLASSES],
    input  logic [csp_pkg::SCORE_W-1:0] i_score [csp_pkg::HW_CLASSES],
    output csp_pkg::t_pick              o_pick
);

    // Lowest firing lane wins
    always_comb begin
        o_pick = '0;
        for (int i = csp_pkg::HW_CLASSES - 1; i >= 0; i--) begin
            if (i_hit[i]) begin
                o_pick.fire  = 1'b1;
                o_pick.idx   = csp_pkg::IDX_W'(i);
                o_pick.score = i_score[i];
            end
        end
    end

endmodule

// ===== sv/csp_out.sv =====
module csp_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  csp_pkg::t_evt      i_evt,
    output logic               o_adv,
    csp_out_if.source          o_out
);

    logic                         r_v1, r_v2, r_v3;
    csp_pkg::t_evt                r_e1;
    logic                         r_game2;
    logic [csp_pkg::IDX_W-1:0]    r_code2;
    logic [csp_pkg::CONF_W-1:0]   r_conf2;
    logic [csp_pkg::SQ_W-1:0]     r_sq2;
    logic [csp_pkg::MODE_W-1:0]   r_mode2;

    logic [csp_pkg::SCORE_W+csp_pkg::CONF_W-1:0] n_conf_prod;
    logic [2*csp_pkg::MAG_W-1:0]                 n_sq_prod;
    logic [csp_pkg::SQ_W+csp_pkg::CONF_W-1:0]    n_lvl_prod;
    logic [csp_pkg::LEVEL_W-1:0]                 n_level;

    // Whole pipe moves unless the output register is held
    assign o_adv = !r_v3 || o_out.ready;

    assign n_conf_prod = (csp_pkg::SCORE_W + csp_pkg::CONF_W)'(r_e1.score)
                       * (csp_pkg::SCORE_W + csp_pkg::CONF_W)'(csp_pkg::PCT_SCALE);
    assign n_sq_prod   = (2*csp_pkg::MAG_W)'(r_e1.mag) * (2*csp_pkg::MAG_W)'(r_e1.mag);

    // Square at most 2^30, so level stays under 6401 and never saturates
    assign n_lvl_prod  = (csp_pkg::SQ_W + csp_pkg::CONF_W)'(r_sq2)
                       * (csp_pkg::SQ_W + csp_pkg::CONF_W)'(csp_pkg::PCT_SCALE);
    assign n_level     = csp_pkg::LEVEL_W'(n_lvl_prod[csp_pkg::SQ_W+csp_pkg::CONF_W-1:24]);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (o_adv) begin
            r_v1 <= i_load;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload stages: capture, multiply, scale
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_e1    <= i_evt;
            r_game2 <= r_e1.game;
            r_code2 <= csp_pkg::map_code(r_e1.idx);
            r_conf2 <= n_conf_prod[csp_pkg::SCORE_W+csp_pkg::CONF_W-1:csp_pkg::SCORE_W];
            r_sq2   <= n_sq_prod[csp_pkg::SQ_W-1:0];
            r_mode2 <= r_e1.mode;
            o_out.event_kind     <= r_game2 ? csp_pkg::EVT_GAME : csp_pkg::EVT_GESTURE;
            o_out.gesture_code   <= r_code2;
            o_out.confidence_pct <= r_conf2;
            o_out.anomaly_level  <= r_game2 ? '0 : n_level;
            o_out.mode_echo      <= r_game2 ? r_mode2 : '0;
        end
    end

    assign o_out.valid = r_v3;

endmodule

// ===== sv/class_score_persistence_gate.sv =====
// Class score persistence gate: eight score lanes and a lowest-class merge.
// Pipeline: three register stages (capture, multiply, scale) from input transfer to result.
// Throughput: one frame per cycle; the output register is the only stall point.
// Reset (i_rst_n low, synchronous): run counters cleared, pipeline emptied,
// registers back to their defaults. Configuration port is always ready.
module class_score_persistence_gate #(
    parameter int NUM_CLASSES   = 8,
    parameter int SKIPPED_CLASS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csp_cfg_if.sink       i_cfg,
    csp_in_if.sink        i_in,
    csp_out_if.source     o_out
);

    logic [csp_pkg::CCOUNT_W-1:0]   r_class_count;
    logic [csp_pkg::CFG_DATA_W-1:0] r_count_limits;
    logic [csp_pkg::CFG_DATA_W-1:0] r_prob_lo;
    logic [csp_pkg::CFG_DATA_W-1:0] r_prob_hi;
    logic [csp_pkg::MODE_W-1:0]     r_game_mode;

    logic                        scores [csp_pkg::HW_CLASSES];
    logic [csp_pkg::SCORE_W-1:0] score_arr [csp_pkg::HW_CLASSES];
    logic                        hit    [csp_pkg::HW_CLASSES];
    csp_pkg::t_pick              pick;
    csp_pkg::t_evt               evt;
    logic                        adv;
    logic                        accept;
    logic                        game;
    logic                        emit;
    logic [csp_pkg::MAG_W-1:0]   mag;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count  <= csp_pkg::RST_CLASS_COUNT;
            r_count_limits <= csp_pkg::RST_COUNT_LIMITS;
            r_prob_lo      <= '0;
            r_prob_hi      <= '0;
            r_game_mode    <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                csp_pkg::CFG_CLASS_COUNT:  r_class_count  <= i_cfg.data[csp_pkg::CCOUNT_W-1:0];
                csp_pkg::CFG_COUNT_LIMITS: r_count_limits <= i_cfg.data;
                csp_pkg::CFG_PROB_LOW:     r_prob_lo      <= i_cfg.data;
                csp_pkg::CFG_PROB_HIGH:    r_prob_hi      <= i_cfg.data;
                csp_pkg::CFG_GAME_MODE:    r_game_mode    <= i_cfg.data[csp_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input transfer
    assign i_in.ready = adv;
    assign accept     = i_in.valid && adv;

    assign score_arr[0] = i_in.score_0;
    assign score_arr[1] = i_in.score_1;
    assign score_arr[2] = i_in.score_2;
    assign score_arr[3] = i_in.score_3;
    assign score_arr[4] = i_in.score_4;
    assign score_arr[5] = i_in.score_5;
    assign score_arr[6] = i_in.score_6;
    assign score_arr[7] = i_in.score_7;

    // One lane per class
    for (genvar i = 0; i < csp_pkg::HW_CLASSES; i++) begin : g_lane
        logic [csp_pkg::SCORE_W-1:0] prob_limit;
        logic                        in_use;

        if (i < 4) begin : g_lo
            assign prob_limit = r_prob_lo[csp_pkg::SCORE_W*i +: csp_pkg::SCORE_W];
        end else begin : g_hi
            assign prob_limit = r_prob_hi[csp_pkg::SCORE_W*(i-4) +: csp_pkg::SCORE_W];
        end

        assign in_use = (i < NUM_CLASSES) && (i != SKIPPED_CLASS)
                     && (r_class_count > csp_pkg::CCOUNT_W'(i));
        assign scores[i] = in_use;

        csp_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_accept      (accept),
            .i_in_use      (scores[i]),
            .i_clear       (pick.fire),
            .i_score       (score_arr[i]),
            .i_prob_limit  (prob_limit),
            .i_count_limit (r_count_limits[csp_pkg::CNT_W*i +: csp_pkg::CNT_W]),
            .o_hit         (hit[i])
        );
    end

    // Pick the lowest firing class
    csp_merge u_merge (
        .i_hit   (hit),
        .i_score (score_arr),
        .o_pick  (pick)
    );

    // Route the event; gesture events drop while audio is busy
    assign game = (r_game_mode == csp_pkg::MODE_SWAPPED)
               || (r_game_mode == csp_pkg::MODE_MIRROR);
    assign emit = pick.fire && (game || !i_in.audio_busy);
    assign mag  = i_in.anomaly_score[csp_pkg::SCORE_W-1]
                ? csp_pkg::MAG_W'(-$signed({i_in.anomaly_score[csp_pkg::SCORE_W-1],
                                            i_in.anomaly_score}))
                : csp_pkg::MAG_W'(i_in.anomaly_score);

    always_comb begin
        evt       = '0;
        evt.game  = game;
        evt.idx   = pick.idx;
        evt.score = pick.score;
        evt.mag   = mag;
        evt.mode  = r_game_mode;
    end

    csp_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && emit),
        .i_evt   (evt),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule
